@@ rtl/core/pidaw_pkg.sv @@
// shared types, constants and helpers of the pid controller with anti-windup
package pidaw_pkg;

  // sample and gain widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 32;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned MulW    = GainW + ErrW;       // gain times error
  localparam int unsigned TermW   = MulW - 16;          // product floored by 2^16
  localparam int unsigned PdW     = TermW + 1;          // p plus d
  localparam int unsigned EsumW   = 48;                 // error sum
  localparam int unsigned ProdW   = 80;                 // ki times error sum
  localparam int unsigned ItermW  = 42;                 // saturated integral term
  localparam int unsigned SumW    = 43;                 // p + i + d
  localparam int unsigned CfgIdxW = 3;

  // error sum rails
  localparam logic signed [EsumW:0] EsumMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [EsumW:0] EsumMin = -49'sh0_8000_0000_0000;

  // integral term rails and the product magnitude where they start
  localparam logic signed [ProdW-1:0]  ProdLim  = 80'sd1 <<< 56;
  localparam logic signed [ItermW-1:0] ItermLim = 42'sd1 <<< 40;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } reg_idx_e;

  // request action codes
  localparam logic ActRun   = 1'b0;
  localparam logic ActClear = 1'b1;

  // rebuild of ki times error sum after a ki write
  typedef enum logic [1:0] {
    RC_IDLE,
    RC_HI,
    RC_LO
  } rebuild_e;

  // request going into the integrator stage
  typedef struct packed {
    logic                     fire;
    logic                     clear;
    logic signed [ErrW-1:0]   err;
    logic signed [MulW-1:0]   ki_err;
    logic signed [PdW-1:0]    pd;
  } loop_in_t;

  // integrator stage result and status
  typedef struct packed {
    logic signed [SumW-1:0] y;
    logic                   held;
    logic                   busy;
  } loop_out_t;

  // floor(prod / 2^16), saturated to +-2^40
  function automatic logic signed [ItermW-1:0] iterm(input logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] shifted;
    shifted = prod >>> 16;
    if (prod >= ProdLim) begin
      iterm = ItermLim;
    end else if (prod <= -ProdLim) begin
      iterm = -ItermLim;
    end else begin
      iterm = shifted[ItermW-1:0];
    end
  endfunction

endpackage

@@ rtl/core/pidaw_if.sv @@
// request and result channel interfaces
interface pidaw_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] setpoint;
  logic signed [15:0] measurement;

  modport source (output valid, action, setpoint, measurement, input ready);
  modport sink   (input valid, action, setpoint, measurement, output ready);
endinterface

interface pidaw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               saturated;
  logic               integrator_held;

  modport source (output valid, drive, saturated, integrator_held, input ready);
  modport sink   (input valid, drive, saturated, integrator_held, output ready);
endinterface

@@ rtl/core/pidaw_integrator.sv @@
// integrator stage: error sum, ki times error sum, anti-windup decision
module pidaw_integrator
  import pidaw_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [GainW-1:0]     ki_i,
  input  logic signed [SampleW-1:0]   out_min_i,
  input  logic signed [SampleW-1:0]   out_max_i,
  input  logic                        rebuild_i,
  input  loop_in_t                    req_i,
  output loop_out_t                   rsp_o
);

  logic signed [EsumW-1:0]  es_q, es_d;
  logic signed [ProdW-1:0]  kies_q, kies_d;
  logic signed [55:0]       part_q, part_d;
  rebuild_e                 rc_q, rc_d;

  logic signed [EsumW:0]    t_raw;
  logic signed [EsumW-1:0]  t_sat;
  logic signed [ProdW-1:0]  ki_ext, ki_x47, prod_t;
  logic signed [ItermW-1:0] i_t, i_old;
  logic signed [SumW-1:0]   tent, y_hold, lo_ext, hi_ext;
  logic signed [56:0]       lo_prod;
  logic                     held;

  // tentative error sum with saturation, and its product with ki
  assign t_raw  = (EsumW+1)'(es_q) + (EsumW+1)'(req_i.err);
  assign ki_ext = ProdW'(ki_i);
  assign ki_x47 = ki_ext <<< 47;

  always_comb begin
    if (t_raw > EsumMax) begin
      t_sat  = EsumMax[EsumW-1:0];
      prod_t = ki_x47 - ki_ext;
    end else if (t_raw < EsumMin) begin
      t_sat  = EsumMin[EsumW-1:0];
      prod_t = -ki_x47;
    end else begin
      t_sat  = t_raw[EsumW-1:0];
      prod_t = kies_q + ProdW'(req_i.ki_err);
    end
  end

  // integral terms for the new and the kept sum
  assign i_t    = iterm(prod_t);
  assign i_old  = iterm(kies_q);
  assign tent   = SumW'(req_i.pd) + SumW'(i_t);
  assign y_hold = SumW'(req_i.pd) + SumW'(i_old);
  assign lo_ext = SumW'(out_min_i);
  assign hi_ext = SumW'(out_max_i);

  // anti-windup: hold when past a rail and the error pushes further out
  always_comb begin
    if (tent > hi_ext) begin
      held = req_i.err > 17'sd0;
    end else if (tent < lo_ext) begin
      held = req_i.err < 17'sd0;
    end else begin
      held = 1'b0;
    end
  end

  assign rsp_o.y    = held ? y_hold : tent;
  assign rsp_o.held = held;
  assign rsp_o.busy = (rc_q != RC_IDLE);

  // low half product for the rebuild
  assign lo_prod = 57'(ki_i) * $signed({1'b0, es_q[23:0]});

  // state update and ki rebuild sequencer
  always_comb begin
    rc_d   = rc_q;
    es_d   = es_q;
    kies_d = kies_q;
    part_d = part_q;
    case (rc_q)
      RC_IDLE: begin
        if (req_i.fire) begin
          if (req_i.clear) begin
            es_d   = '0;
            kies_d = '0;
          end else if (!held) begin
            es_d   = t_sat;
            kies_d = prod_t;
          end
        end
      end
      RC_HI: begin
        part_d = 56'(ki_i) * 56'($signed(es_q[47:24]));
        rc_d   = RC_LO;
      end
      RC_LO: begin
        kies_d = (ProdW'(part_q) <<< 24) + ProdW'(lo_prod);
        rc_d   = RC_IDLE;
      end
      default: begin
        rc_d = RC_IDLE;
      end
    endcase
    if (rebuild_i) begin
      rc_d = RC_HI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= RC_IDLE;
      es_q   <= '0;
      kies_q <= '0;
    end else begin
      rc_q   <= rc_d;
      es_q   <= es_d;
      kies_q <= kies_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
  end

endmodule

@@ rtl/core/pid_controller_antiwindup.sv @@
// top level of the pid controller with derivative on measurement and anti-windup
// One request per clock is accepted unless the output stalls or a rebuild runs; a run request
// has its result presented after the multiply stage, term stage, integrator stage and output
// clamp register, and a clear request gives none. The integrator keeps the product ki times
// error sum, so the loop from one request to the next is only an add and a compare. Writing ki
// rebuilds that product on a 32 by 24 and a 32 by 25 multiplier, during which no request is
// accepted.
module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [GainW-1:0]     cfg_wdata_i,
  pidaw_in_if.sink             in_i,
  pidaw_out_if.source          out_o
);

  // configuration registers
  logic signed [GainW-1:0]   kp_q, ki_q, kd_q;
  logic signed [SampleW-1:0] lo_q, hi_q;
  logic                      rebuild;

  assign rebuild = cfg_we_i && (cfg_idx_i == REG_KI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      lo_q <= 16'sh8000;
      hi_q <= 16'sh7FFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:      kp_q <= cfg_wdata_i;
        REG_KI:      ki_q <= cfg_wdata_i;
        REG_KD:      kd_q <= cfg_wdata_i;
        REG_OUT_MIN: lo_q <= cfg_wdata_i[SampleW-1:0];
        REG_OUT_MAX: hi_q <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic      va_q, vb_q, vc_q, vo_q;
  logic      en_a, en_b, en_c, en_o;
  logic      in_fire;
  loop_in_t  loop_in;
  loop_out_t loop_out;

  assign en_o        = !vo_q || out_o.ready;
  assign en_c        = !vc_q || en_o;
  assign en_b        = !vb_q || en_c;
  assign en_a        = !va_q || en_b;
  assign in_i.ready  = en_a && !loop_out.busy;
  assign in_fire     = in_i.valid && in_i.ready;

  // previous measurement for the derivative
  logic signed [SampleW-1:0] last_q;
  logic                      have_last_q;
  logic signed [ErrW-1:0]    err, dm;

  assign err = ErrW'(in_i.setpoint) - ErrW'(in_i.measurement);
  assign dm  = have_last_q ? (ErrW'(in_i.measurement) - ErrW'(last_q)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      have_last_q <= 1'b0;
    end else if (in_fire) begin
      if (in_i.action == ActClear) begin
        last_q      <= '0;
        have_last_q <= 1'b0;
      end else begin
        last_q      <= in_i.measurement;
        have_last_q <= 1'b1;
      end
    end
  end

  // stage a: gain products
  logic                   clr_a_q;
  logic signed [ErrW-1:0] err_a_q;
  logic signed [MulW-1:0] pe_a_q, de_a_q, ie_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      clr_a_q <= (in_i.action == ActClear);
      err_a_q <= err;
      pe_a_q  <= MulW'(kp_q) * MulW'(err);
      de_a_q  <= MulW'(kd_q) * MulW'(dm);
      ie_a_q  <= MulW'(ki_q) * MulW'(err);
    end
  end

  // stage b: floored p and d terms
  logic signed [MulW-1:0]  de_neg, pe_sh, de_sh;
  logic                    clr_b_q;
  logic signed [ErrW-1:0]  err_b_q;
  logic signed [MulW-1:0]  ie_b_q;
  logic signed [PdW-1:0]   pd_b_q;

  assign de_neg = -de_a_q;
  assign pe_sh  = pe_a_q >>> 16;
  assign de_sh  = de_neg >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      clr_b_q <= clr_a_q;
      err_b_q <= err_a_q;
      ie_b_q  <= ie_a_q;
      pd_b_q  <= PdW'($signed(pe_sh[TermW-1:0])) + PdW'($signed(de_sh[TermW-1:0]));
    end
  end

  // stage c: integrator and anti-windup
  assign loop_in.fire   = vb_q && en_c;
  assign loop_in.clear  = clr_b_q;
  assign loop_in.err    = err_b_q;
  assign loop_in.ki_err = ie_b_q;
  assign loop_in.pd     = pd_b_q;

  pidaw_integrator u_integrator (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ki_i      (ki_q),
    .out_min_i (lo_q),
    .out_max_i (hi_q),
    .rebuild_i (rebuild),
    .req_i     (loop_in),
    .rsp_o     (loop_out)
  );

  logic signed [SumW-1:0] y_c_q;
  logic                   held_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_c) begin
      vc_q <= vb_q && !clr_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      y_c_q    <= loop_out.y;
      held_c_q <= loop_out.held;
    end
  end

  // output register: clamp to the rails, lower rail first
  logic signed [SampleW-1:0] drive_q, drive_d;
  logic                      sat_q, sat_d, held_q;

  always_comb begin
    if (y_c_q < SumW'(lo_q)) begin
      drive_d = lo_q;
      sat_d   = 1'b1;
    end else if (y_c_q > SumW'(hi_q)) begin
      drive_d = hi_q;
      sat_d   = 1'b1;
    end else begin
      drive_d = y_c_q[SampleW-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_o) begin
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
      held_q  <= held_c_q;
    end
  end

  assign out_o.valid           = vo_q;
  assign out_o.drive           = drive_q;
  assign out_o.saturated       = sat_q;
  assign out_o.integrator_held = held_q;

  // checks
  a_rebuild_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rebuild |=> loop_out.busy)
    else $error("ki write did not start the product rebuild");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_out.busy |-> !in_fire)
    else $error("request accepted during product rebuild");

  a_drive_in_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && (lo_q <= hi_q)) |-> ((drive_q >= lo_q) && (drive_q <= hi_q)))
    else $error("drive outside the output rails");

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && sat_q) |-> ((drive_q == lo_q) || (drive_q == hi_q)))
    else $error("saturated flag set but drive not on a rail");

endmodule

@@ tb/tb_pid_controller_antiwindup.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the pid controller with derivative on measurement and anti-windup
module tb_pid_controller_antiwindup;
  import pidaw_pkg::*;

  // q16.16 gains and sample extremes used by the directed rows
  localparam logic [31:0] GainOne    = 32'h0001_0000;
  localparam logic [31:0] GainNegOne = 32'hFFFF_0000;
  localparam logic [31:0] GainTop    = 32'h7FFF_FFFF;
  localparam logic [31:0] GainBottom = 32'h8000_0000;
  localparam logic signed [15:0] SampleTop    = 16'sh7FFF;
  localparam logic signed [15:0] SampleBottom = 16'sh8000;
  localparam int SampleTopInt    = 32767;
  localparam int SampleBottomInt = -32768;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] RegSpareFirst = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareLast  = 3'd7;

  // error sum and integral term rails
  localparam longint EsumTop    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint EsumBottom = -64'sh0000_8000_0000_0000;
  localparam longint ItermRail  = 64'sd1 <<< 40;
  localparam logic signed [127:0] ProdRail = 128'sd1 <<< 56;

  localparam int PhaseCount = 12;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               sat;
    logic               held;
  } drive_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_e;

  typedef struct packed {
    row_e               kind;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    logic               act;
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    logic               typed;
    logic signed [15:0] drive;
    logic               sat;
    logic               held;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [GainW-1:0]   cfg_wdata_i;

  pidaw_in_if  req_if ();
  pidaw_out_if rsp_if ();

  pid_controller_antiwindup DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // directed rows: rails, gain extremes, hold cases, clear and crossed rails
  row_t plan [39] = '{
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleTop, SampleBottom, 1'b1, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleBottom, SampleTop, 1'b1, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActClear, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KP, GainOne, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd100, 16'sd0, 1'b1, 16'sd100, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleTop, SampleBottom, 1'b1, SampleTop, 1'b1, 1'b1},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleBottom, SampleTop, 1'b1, SampleBottom, 1'b1, 1'b1},
    '{ROW_WRITE, REG_KP, GainNegOne, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_OUT_MAX, 32'd500, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, -16'sd1000, 16'sd0, 1'b1, 16'sd500, 1'b1, 1'b0},
    '{ROW_WRITE, REG_KI, 32'h0000_8000, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KD, 32'h0002_0000, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd200, 16'sd50, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd200, 16'sd150, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd200, 16'sd400, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActClear, SampleTop, SampleBottom, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd0, 16'sd1234, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KP, GainTop, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KI, GainBottom, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KD, GainTop, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_OUT_MIN, 32'h0000_8000, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_OUT_MAX, 32'h0000_7FFF, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleTop, SampleBottom, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleBottom, SampleTop, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd0, SampleBottom, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KP, GainBottom, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KI, GainTop, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KD, GainBottom, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleTop, SampleBottom, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, SampleBottom, SampleTop, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_OUT_MIN, 32'd100, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_OUT_MAX, 32'hFFFF_FF9C, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KP, GainOne, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KI, 32'd0, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_KD, 32'd0, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd0, 16'sd0, 1'b1, 16'sd100, 1'b1, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, 16'sd1000, 16'sd0, 1'b1, -16'sd100, 1'b1, 1'b1},
    '{ROW_WRITE, RegSpareLast, 32'hDEAD_BEEF, ActRun, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_KP, 32'd0, ActRun, -16'sd1000, 16'sd0, 1'b1, 16'sd100, 1'b1, 1'b1}
  };

  // controller copy: registers and state
  logic signed [31:0] kp_gain   = '0;
  logic signed [31:0] ki_gain   = '0;
  logic signed [31:0] kd_gain   = '0;
  logic signed [15:0] rail_lo   = SampleBottom;
  logic signed [15:0] rail_hi   = SampleTop;
  longint             error_acc = 0;
  logic signed [15:0] prev_meas = '0;
  logic               have_prev = 1'b0;

  drive_t expected_drives [$];
  int requests_taken = 0;
  int faults = 0;
  int hold_left = 0;
  bit holdoff_done = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // floor(ki * s / 2^16), railed at +-2^40
  function automatic longint integral_term(input logic signed [31:0] g, input longint s);
    logic signed [127:0] gw;
    logic signed [127:0] sw;
    logic signed [127:0] prod;
    logic signed [127:0] shifted;
    gw = 128'(g);
    sw = 128'(s);
    prod = gw * sw;
    shifted = prod >>> 16;
    if (prod >= ProdRail) begin
      integral_term = ItermRail;
    end else if (prod <= -ProdRail) begin
      integral_term = -ItermRail;
    end else begin
      integral_term = shifted[63:0];
    end
  endfunction

  // one control step: updates the state copy and returns the drive it produces
  function automatic drive_t next_drive(input logic signed [15:0] sp, input logic signed [15:0] ms);
    longint e, dm, p, d, t, tent, y, lo, hi;
    drive_t r;
    e = longint'(sp);
    e = e - ms;
    dm = 0;
    if (have_prev) begin
      dm = longint'(ms);
      dm = dm - prev_meas;
    end
    prev_meas = ms;
    have_prev = 1'b1;
    p = (longint'(kp_gain) * e) >>> 16;
    d = (-(longint'(kd_gain) * dm)) >>> 16;
    t = error_acc + e;
    if (t > EsumTop) t = EsumTop;
    if (t < EsumBottom) t = EsumBottom;
    tent = p + integral_term(ki_gain, t) + d;
    lo = longint'(rail_lo);
    hi = longint'(rail_hi);
    // anti-windup: hold when past a rail and the error pushes further out
    r.held = 1'b0;
    if (tent > hi) begin
      r.held = (e > 0);
    end else if (tent < lo) begin
      r.held = (e < 0);
    end
    if (!r.held) error_acc = t;
    // output clamp, lower rail first
    y = p + integral_term(ki_gain, error_acc) + d;
    r.sat = 1'b0;
    if (y < lo) begin
      y = lo;
      r.sat = 1'b1;
    end else if (y > hi) begin
      y = hi;
      r.sat = 1'b1;
    end
    r.drive = y[15:0];
    return r;
  endfunction

  // no idling on either side in this window
  function automatic bit calm_stretch();
    return requests_taken >= 400 && requests_taken < 650;
  endfunction

  // random gain: mostly moderate within +-span, sometimes zero or extreme
  function automatic logic [31:0] pick_gain(input int unsigned span);
    case ($urandom_range(9))
      0: pick_gain = '0;
      1: pick_gain = GainTop;
      2: pick_gain = GainBottom;
      3: pick_gain = $urandom();
      default: pick_gain = $urandom_range(2 * span) - span;
    endcase
  endfunction

  // register write, mirrored into the controller copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      REG_KP:      kp_gain = data;
      REG_KI:      ki_gain = data;
      REG_KD:      kd_gain = data;
      REG_OUT_MIN: rail_lo = data[15:0];
      REG_OUT_MAX: rail_hi = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait until every drive is back and the pipeline has emptied
  task automatic settle();
    while (expected_drives.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // offer one request, predict at acceptance; starts and ends at a falling edge
  task automatic push_request(input logic act, input logic signed [15:0] sp,
                              input logic signed [15:0] ms, input logic typed,
                              input drive_t typed_want);
    drive_t got;
    while (!calm_stretch() && $urandom_range(99) < 6) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.action      = act;
    req_if.setpoint    = sp;
    req_if.measurement = ms;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_taken++;
    if (act == ActClear) begin
      error_acc = 0;
      prev_meas = '0;
      have_prev = 1'b0;
    end else begin
      got = next_drive(sp, ms);
      expected_drives.push_back(typed ? typed_want : got);
    end
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && requests_taken >= 900) begin
        hold_left = 120;
        holdoff_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = calm_stretch() ? 1'b1 : ($urandom_range(99) >= 6);
      end
    end
  end

  // compare each returned drive with the oldest prediction
  always @(posedge clk_i) begin : check_drive
    drive_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_drives.size() == 0) begin
        $error("unexpected drive result: drive=%0d", rsp_if.drive);
        faults++;
      end else begin
        want = expected_drives.pop_front();
        if (rsp_if.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, rsp_if.drive);
          faults++;
        end
        if (rsp_if.saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, rsp_if.saturated);
          faults++;
        end
        if (rsp_if.integrator_held !== want.held) begin
          $error("integrator_held: expected %0b, got %0b", want.held, rsp_if.integrator_held);
          faults++;
        end
      end
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb_pid_controller_antiwindup: errors");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    drive_t want;
    int sp_v, ms_v, lo_v, hi_v, pick, n_items, waited;
    logic act;
    logic signed [15:0] sp_f, ms_f;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_KP;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.action      = ActRun;
    req_if.setpoint    = '0;
    req_if.measurement = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        want.drive = plan[i].drive;
        want.sat   = plan[i].sat;
        want.held  = plan[i].held;
        push_request(plan[i].act, plan[i].sp, plan[i].ms, plan[i].typed, want);
      end
    end

    // random phases: new settings, then a tracking loop with noise and clears
    want = '0;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      write_reg(REG_KP, pick_gain(32'h0004_0000));
      write_reg(REG_KI, pick_gain(32'h0000_8000));
      write_reg(REG_KD, pick_gain(32'h0002_0000));
      case ($urandom_range(9))
        0, 1: begin
          lo_v = SampleBottomInt;
          hi_v = SampleTopInt;
        end
        2: begin
          lo_v = int'($urandom_range(1, 3000));
          hi_v = -int'($urandom_range(3000));
        end
        3: begin
          lo_v = int'($urandom_range(4000)) - 2000;
          hi_v = lo_v;
        end
        default: begin
          lo_v = int'($urandom_range(6000)) - 3000;
          hi_v = lo_v + int'($urandom_range(8000));
        end
      endcase
      write_reg(REG_OUT_MIN, {16'($urandom()), 16'(lo_v)});
      write_reg(REG_OUT_MAX, {16'($urandom()), 16'(hi_v)});
      if ($urandom_range(3) == 0) begin
        write_reg(3'($urandom_range(RegSpareFirst, RegSpareLast)), $urandom());
      end

      sp_v = int'($urandom_range(8000)) - 4000;
      ms_v = int'($urandom_range(8000)) - 4000;
      n_items = $urandom_range(110, 170);
      for (int k = 0; k < n_items; k++) begin
        act = ActRun;
        // occasional setpoint step, sometimes to a sample extreme
        if ($urandom_range(99) < 4) begin
          pick = $urandom_range(3);
          sp_v = (pick == 0) ? SampleTopInt : (pick == 1) ? SampleBottomInt :
                 int'($urandom_range(65535)) - 32768;
        end
        sp_f = 16'(sp_v);
        pick = $urandom_range(99);
        if (pick < 3) begin
          act  = ActClear;
          sp_f = 16'($urandom());
          ms_f = 16'($urandom());
        end else if (pick < 15) begin
          sp_f = 16'($urandom());
          ms_f = 16'($urandom());
        end else if (pick < 18) begin
          ms_f = $urandom_range(1) ? SampleTop : SampleBottom;
        end else begin
          // plant-like walk toward the setpoint with noise
          ms_v = ms_v + (sp_v - ms_v) / 8 + int'($urandom_range(200)) - 100;
          if (ms_v > SampleTopInt) ms_v = SampleTopInt;
          if (ms_v < SampleBottomInt) ms_v = SampleBottomInt;
          ms_f = 16'(ms_v);
        end
        push_request(act, sp_f, ms_f, 1'b0, want);
      end
    end

    // drain with a bound, then report
    waited = 0;
    while (expected_drives.size() != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (expected_drives.size() != 0) begin
      $error("%0d drive results never arrived", expected_drives.size());
      faults++;
    end
    if (faults == 0) begin
      $display("tb_pid_controller_antiwindup: clean");
    end else begin
      $display("tb_pid_controller_antiwindup: errors");
    end
    $finish;
  end

endmodule
